// ===== hdl/ppghr_pkg.sv =====
// Package for the PPG heart-rate peak detector.
// Holds shared constants, the queue entry type and the back-end state type.
// No dependencies.
`default_nettype none

package ppghr_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 18;
   localparam int RATE_W    = 10;
   localparam int BPM_W     = 8;

   // Default store capacity and the depth of the front-to-back queue.
   localparam int CAPACITY_DEFAULT = 2048;
   localparam int QUEUE_DEPTH      = 4;

   // Sample rate after reset.
   localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

   // Evaluation limits.
   localparam int MIN_SAMPLES = 10;
   localparam int MIN_PEAKS   = 2;
   localparam int BPM_MIN     = 40;
   localparam int BPM_MAX     = 200;

   // Twice the seconds per minute, used for round-half-up in the rate.
   localparam int BPM_SCALE  = 120;
   localparam int RATE120_W  = 17;

   // One classified sample as it travels from the front end to the back end.
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
      logic                store;
   } queue_entry_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_START,
      BACK_WALK,
      BACK_MULT,
      BACK_DIV_GO,
      BACK_DIV_WAIT,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/ppghr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppghr_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ppghr_fifo.sv =====
// Small register queue between the front end and the back end.
// No dependencies.
`default_nettype none

module ppghr_fifo #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ppghr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module ppghr_divider #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   // One shift-subtract step per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ===== hdl/ppghr_front.sv =====
// Front end: accepts samples, marks which ones fit in the store, and queues them.
// Depends on ppghr_pkg.
`default_nettype none

module ppghr_front #(
   parameter int CAPACITY = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [ppghr_pkg::SAMPLE_W-1:0] sample_value,
   input  logic                           last_sample,
   output logic                           q_push,
   output ppghr_pkg::queue_entry_type     q_entry,
   input  logic                           q_full
);

   import ppghr_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             fits;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign fits   = (count_ff < CNT_W'(CAPACITY));

   // Classify the sample; a sample past capacity is passed on marked as not stored.
   always_comb begin
      q_entry.value = sample_value;
      q_entry.last  = last_sample;
      q_entry.store = fits;
      q_push        = accept;
   end

   // Window fill count, cleared at each window end.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (last_sample) begin
            count_in = '0;
         end else if (fits) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ppghr_back.sv =====
// Back end: stores samples, walks the window for peaks, computes the rate.
// Depends on ppghr_pkg, ppghr_ram and ppghr_divider.
`default_nettype none

module ppghr_back #(
   parameter int CAPACITY = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ppghr_pkg::RATE_W-1:0]   csr_wr_data,
   input  ppghr_pkg::queue_entry_type     q_entry,
   input  logic                           q_empty,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_rate_valid,
   output logic [ppghr_pkg::BPM_W-1:0]    rsp_heart_rate_bpm
);

   import ppghr_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int NUM_W  = RATE120_W + CNT_W + 1;
   localparam int DEN_W  = CNT_W + 1;
   localparam int GAP_W  = (CNT_W + 5 > RATE_W + 2) ? CNT_W + 5 : RATE_W + 2;
   localparam int THR_W  = SAMPLE_W + 3;

   back_state_type       state_ff, state_in;
   logic [RATE_W-1:0]    rate_ff;
   logic [RATE120_W-1:0] rate120_ff, rate120_in;
   logic [CNT_W-1:0]     wptr_ff, wptr_in;
   logic [SAMPLE_W-1:0]  peak_ff, peak_in;
   logic [CNT_W-1:0]     ra_ff, ra_in;
   logic                 rv_ff, rv_in;
   logic [CNT_W-1:0]     di_ff, di_in;
   logic [SAMPLE_W-1:0]  s0_ff, s0_in;
   logic [SAMPLE_W-1:0]  s1_ff, s1_in;
   logic [CNT_W-1:0]     peaks_ff, peaks_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     prev_ff, prev_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic                 res_ok_ff, res_ok_in;
   logic [BPM_W-1:0]     res_bpm_ff, res_bpm_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_ok_ff, out_ok_in;
   logic [BPM_W-1:0]     out_bpm_ff, out_bpm_in;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [SAMPLE_W-1:0]  ram_rd_data;
   logic                 div_start;
   logic                 div_done;
   logic [NUM_W-1:0]     div_quot;

   logic [CNT_W-1:0]     center;
   logic [CNT_W-1:0]     gap;
   logic [CNT_W-1:0]     sum;
   logic [CNT_W-1:0]     k;
   logic                 above_thr;
   logic                 is_peak;
   logic                 gap_ok;
   logic                 quot_ok;

   // Sample store.
   ppghr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff[ADDR_W-1:0]),
      .wr_data (q_entry.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ra_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Rate divider.
   ppghr_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Peak test on the center of the three-sample window.
   // v > floor(4*peak/10) is the same as 5*v > 2*peak.
   assign center    = di_ff - CNT_W'(1);
   assign above_thr = ((THR_W'(s1_ff) << 2) + THR_W'(s1_ff)) > (THR_W'(peak_ff) << 1);
   assign is_peak   = rv_ff && (di_ff >= CNT_W'(2)) && (s1_ff > s0_ff) &&
                      (s1_ff > ram_rd_data) && above_thr;

   // Gap test: d >= floor(3*rate/10) is the same as 10*d + 10 > 3*rate.
   assign gap    = center - prev_ff;
   assign gap_ok = ((GAP_W'(gap) << 3) + (GAP_W'(gap) << 1) + GAP_W'(10)) >
                   ((GAP_W'(rate_ff) << 1) + GAP_W'(rate_ff));

   assign sum     = prev_ff - first_ff;
   assign k       = peaks_ff - CNT_W'(1);
   assign quot_ok = (div_quot >= NUM_W'(BPM_MIN)) && (div_quot <= NUM_W'(BPM_MAX));

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      rate120_in   = rate120_ff;
      wptr_in      = wptr_ff;
      peak_in      = peak_ff;
      ra_in        = ra_ff;
      rv_in        = 1'b0;
      di_in        = di_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      peaks_in     = peaks_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      res_ok_in    = res_ok_ff;
      res_bpm_in   = res_bpm_ff;
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_bpm_in   = out_bpm_ff;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      div_start    = 1'b0;

      // A result transfer empties the output register.
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.store) begin
                  ram_wr_en = 1'b1;
                  wptr_in   = wptr_ff + CNT_W'(1);
                  if (q_entry.value > peak_ff) begin
                     peak_in = q_entry.value;
                  end
               end
               if (q_entry.last) begin
                  state_in = BACK_START;
               end
            end
         end

         BACK_START: begin
            rate120_in = RATE120_W'(rate_ff) * RATE120_W'(BPM_SCALE);
            ra_in      = '0;
            peaks_in   = '0;
            first_in   = '0;
            prev_in    = '0;
            if (wptr_ff < CNT_W'(MIN_SAMPLES)) begin
               res_ok_in  = 1'b0;
               res_bpm_in = '0;
               state_in   = BACK_DONE;
            end else begin
               state_in = BACK_WALK;
            end
         end

         BACK_WALK: begin
            // Issue one read per cycle; data returns the next cycle.
            if (ra_ff < wptr_ff) begin
               ram_rd_en = 1'b1;
               rv_in     = 1'b1;
               di_in     = ra_ff;
               ra_in     = ra_ff + CNT_W'(1);
            end
            if (rv_ff) begin
               s0_in = s1_ff;
               s1_in = ram_rd_data;
               if (is_peak) begin
                  if (peaks_ff == '0) begin
                     first_in = center;
                     prev_in  = center;
                     peaks_in = CNT_W'(1);
                  end else if (gap_ok) begin
                     prev_in  = center;
                     peaks_in = peaks_ff + CNT_W'(1);
                  end
               end
               if (di_ff == wptr_ff - CNT_W'(1)) begin
                  state_in = BACK_MULT;
               end
            end
         end

         BACK_MULT: begin
            num_in = NUM_W'(rate120_ff) * NUM_W'(k) + NUM_W'(sum);
            den_in = {sum, 1'b0};
            if ((peaks_ff < CNT_W'(MIN_PEAKS)) || (sum == '0)) begin
               res_ok_in  = 1'b0;
               res_bpm_in = '0;
               state_in   = BACK_DONE;
            end else begin
               state_in = BACK_DIV_GO;
            end
         end

         BACK_DIV_GO: begin
            div_start = 1'b1;
            state_in  = BACK_DIV_WAIT;
         end

         BACK_DIV_WAIT: begin
            if (div_done) begin
               res_ok_in  = quot_ok;
               res_bpm_in = quot_ok ? div_quot[BPM_W-1:0] : '0;
               state_in   = BACK_DONE;
            end
         end

         BACK_DONE: begin
            // Hand the result over once the output register is free.
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_ok_in    = res_ok_ff;
               out_bpm_in   = res_bpm_ff;
               wptr_in      = '0;
               peak_in      = '0;
               state_in     = BACK_IDLE;
            end
         end

         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rate_ff      <= RATE_RESET;
         wptr_ff      <= '0;
         peak_ff      <= '0;
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         peak_ff      <= peak_in;
         rv_ff        <= rv_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            rate_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rate120_ff <= rate120_in;
      ra_ff      <= ra_in;
      di_ff      <= di_in;
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      peaks_ff   <= peaks_in;
      first_ff   <= first_in;
      prev_ff    <= prev_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      res_ok_ff  <= res_ok_in;
      res_bpm_ff <= res_bpm_in;
      out_ok_ff  <= out_ok_in;
      out_bpm_ff <= out_bpm_in;
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_rate_valid     = out_ok_ff;
   assign rsp_heart_rate_bpm = out_bpm_ff;

endmodule

`default_nettype wire

// ===== hdl/ppg_heart_rate_peak_detector.sv =====
// Top level of the PPG heart-rate peak detector.
// Depends on ppghr_pkg, ppghr_front, ppghr_fifo and ppghr_back.
//
//   Port group  Direction  Transfer condition        Content
//   req_*       in         req_push  & !req_full     one sample and its last flag
//   rsp_*       out        rsp_pop   & !rsp_empty    rate_valid and heart_rate_bpm
//   csr_*       in         csr_wr_en                 sample rate in Hz
//
// Samples reach the store at one per cycle via a four-entry queue while the back end idles.
// A last sample starts the evaluation: a walk over the n stored samples, a start and run
// of the one-bit-per-cycle divider, and a hand-over of the result to the output register;
// too few samples skip the walk and the divider, and too few peaks skip the divider.
// While the window is evaluated, further samples wait in the queue and req_full rises
// once it fills. A finished result sits in the output register until popped.
// Reset is synchronous and active high; the sample store needs no clearing.
`default_nettype none

module ppg_heart_rate_peak_detector #(
   parameter int CAPACITY = ppghr_pkg::CAPACITY_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ppghr_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                           req_last_sample,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_rate_valid,
   output logic [ppghr_pkg::BPM_W-1:0]    rsp_heart_rate_bpm,
   input  logic                           csr_wr_en,
   input  logic [ppghr_pkg::RATE_W-1:0]   csr_wr_data
);

   import ppghr_pkg::*;

   localparam int ENTRY_W = $bits(queue_entry_type);

   queue_entry_type front_entry;
   queue_entry_type back_entry;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_empty;

   // Front end: sample intake and classification.
   ppghr_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .sample_value (req_sample_value),
      .last_sample  (req_last_sample),
      .q_push       (q_push),
      .q_entry      (front_entry),
      .q_full       (q_full)
   );

   // Queue decoupling intake from evaluation.
   ppghr_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (front_entry),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (back_entry),
      .empty   (q_empty)
   );

   // Back end: storage, peak walk and rate computation.
   ppghr_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_entry            (back_entry),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_rate_valid     (rsp_rate_valid),
      .rsp_heart_rate_bpm (rsp_heart_rate_bpm)
   );

endmodule

`default_nettype wire
